/* sv/spa_pkg.sv */
package spa_pkg;

  // Atlas geometry and table sizes.
  localparam int PAGE_SIZE_LOG2 = 8;
  localparam int MAX_PAGES      = 16;
  localparam int MAX_RES        = 1024;
  localparam int MAX_SPRITES    = 256;
  localparam int PAGE_W         = 4;
  localparam int ID_W           = 10;
  localparam int REC_W          = 8;
  localparam int CNT_W          = 9;
  localparam int PCNT_W         = 5;
  localparam int SLOT_W         = 10;
  localparam int TOP_W          = 11;
  localparam int CLS_W          = 4;
  localparam int DIM_W          = 12;
  localparam int POS_W          = 8;
  localparam int EDGE_W         = 13;
  localparam int CELL_W         = 13;
  localparam int MIN_CLASS      = 3;
  localparam int MAX_CLASS      = 12;
  localparam int SLOTS_MAX      = 1024;
  localparam int STACK_AW       = PAGE_W + SLOT_W;
  localparam int PLACE_W        = PAGE_W + SLOT_W + ID_W;
  localparam int BOUNDS_W       = 2 * POS_W + 2 * EDGE_W;
  localparam int MAP_W          = REC_W + 1;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PAGES    = 2'd1;
  localparam logic [1:0] ST_TABLE    = 2'd2;
  localparam logic [1:0] ST_UNCACHED = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [ID_W-1:0]   resource_id;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [1:0]        status;
    logic [PAGE_W-1:0] page_index;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  left;
    logic [POS_W-1:0]  top;
    logic [EDGE_W-1:0] right;
    logic [EDGE_W-1:0] bottom;
    logic [CELL_W-1:0] cell_size;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_REC,
    S_RECUSE,
    S_SWAP_WR,
    S_DEC,
    S_SCAN,
    S_FILL,
    S_POP,
    S_PLACE,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take_in;
    logic       clear_sweep;
    logic       rec_rd;
    logic       rec_last;
    logic       pg_from_rec;
    logic       res_rec;
    logic       res_err;
    logic [1:0] err_code;
    logic       unmap;
    logic       swap_wr;
    logic       dec;
    logic       scan_start;
    logic       scan_next;
    logic       open_page;
    logic       fill;
    logic       pop;
    logic       place;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic cached;
    logic table_full;
    logic is_last;
    logic scan_match;
    logic scan_more;
    logic pages_full;
    logic fill_last;
    logic clr_last;
    logic out_free;
  } sts_t;

  // Size class: ceil(log2(max(w, h, 8))), capped at the largest class.
  function automatic logic [CLS_W-1:0] size_class(logic [DIM_W-1:0] w,
                                                  logic [DIM_W-1:0] h);
    logic [DIM_W-1:0] s;
    logic [CLS_W-1:0] c;
    s = (w > h) ? w : h;
    c = CLS_W'(MIN_CLASS);
    for (int i = MIN_CLASS; i < MAX_CLASS; i++) begin
      if ({1'b0, s} > (13'(1) << i)) begin
        c = CLS_W'(i + 1);
      end
    end
    return c;
  endfunction

  // Number of column bits of a page of the given class.
  function automatic logic [CLS_W-1:0] col_bits(logic [CLS_W-1:0] c);
    return (c < CLS_W'(PAGE_SIZE_LOG2)) ? CLS_W'(CLS_W'(PAGE_SIZE_LOG2) - c) : '0;
  endfunction

endpackage

/* sv/sprite_atlas_slot_allocator.sv */
// Channel | Signals                       | Moves
// in      | in_valid, in_ready, in_data   | load or invalidate request
// out     | out_valid, out_ready, out_data| one result per request
//
// One request is worked at a time by a state machine over a single datapath.
// A load scans the open pages (up to 16) for one of its class with a free slot,
// or else opens a new page and fills its free stack (up to 1024 slots for the
// smallest class). After reset a clearing pass sweeps the id map; no request is
// taken meanwhile. A finished result waits in an output register while the next
// request is taken; it is stalled only when that register is still full.
module sprite_atlas_slot_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  spa_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output spa_pkg::out_t out_data
);

  spa_pkg::cmd_t cmd;
  spa_pkg::sts_t sts;

  // Sequencer.
  spa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Tables, stacks and result registers.
  spa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* sv/spa_ctrl.sv */
module spa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output spa_pkg::cmd_t cmd,
  input  spa_pkg::sts_t sts
);

  spa_pkg::state_t state;
  spa_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      spa_pkg::S_CLEAR: begin
        cmd.clear_sweep = 1'b1;
        if (sts.clr_last) begin
          state_next = spa_pkg::S_IDLE;
        end
      end
      spa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = spa_pkg::S_LOOKUP;
        end
      end
      spa_pkg::S_LOOKUP: begin
        if (sts.cached) begin
          cmd.rec_rd = 1'b1;
          state_next = spa_pkg::S_REC;
        end else if (sts.mode) begin
          cmd.res_err  = 1'b1;
          cmd.err_code = spa_pkg::ST_UNCACHED;
          state_next   = spa_pkg::S_DONE;
        end else if (sts.table_full) begin
          cmd.res_err  = 1'b1;
          cmd.err_code = spa_pkg::ST_TABLE;
          state_next   = spa_pkg::S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = spa_pkg::S_SCAN;
        end
      end
      spa_pkg::S_REC: begin
        cmd.pg_from_rec = 1'b1;
        state_next      = spa_pkg::S_RECUSE;
      end
      spa_pkg::S_RECUSE: begin
        cmd.res_rec = 1'b1;
        if (!sts.mode) begin
          state_next = spa_pkg::S_DONE;
        end else begin
          cmd.unmap = 1'b1;
          if (sts.is_last) begin
            state_next = spa_pkg::S_DEC;
          end else begin
            cmd.rec_rd   = 1'b1;
            cmd.rec_last = 1'b1;
            state_next   = spa_pkg::S_SWAP_WR;
          end
        end
      end
      spa_pkg::S_SWAP_WR: begin
        cmd.swap_wr = 1'b1;
        state_next  = spa_pkg::S_DEC;
      end
      spa_pkg::S_DEC: begin
        cmd.dec    = 1'b1;
        state_next = spa_pkg::S_DONE;
      end
      spa_pkg::S_SCAN: begin
        if (sts.scan_match) begin
          state_next = spa_pkg::S_POP;
        end else if (sts.scan_more) begin
          cmd.scan_next = 1'b1;
        end else if (sts.pages_full) begin
          cmd.res_err  = 1'b1;
          cmd.err_code = spa_pkg::ST_PAGES;
          state_next   = spa_pkg::S_DONE;
        end else begin
          cmd.open_page = 1'b1;
          state_next    = spa_pkg::S_FILL;
        end
      end
      spa_pkg::S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) begin
          state_next = spa_pkg::S_POP;
        end
      end
      spa_pkg::S_POP: begin
        cmd.pop    = 1'b1;
        state_next = spa_pkg::S_PLACE;
      end
      spa_pkg::S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = spa_pkg::S_DONE;
      end
      spa_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = spa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spa_pkg::S_IDLE;
      end
    endcase
  end

  // A request is only taken once the clearing pass is over.
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == spa_pkg::S_CLEAR) |-> !cmd.take_in)
    else $error("request taken during clearing pass");

  // Every request ends in exactly one result load before the next is taken.
  a_load_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (state == spa_pkg::S_IDLE))
    else $error("result load did not return to idle");

  // Filling only follows the opening of a page.
  a_fill_after_open: assert property (@(posedge clk) disable iff (rst)
    $rose(state == spa_pkg::S_FILL) |-> $past(cmd.open_page))
    else $error("fill entered without opening a page");

endmodule

/* sv/spa_dp.sv */
module spa_dp (
  input  logic           clk,
  input  logic           rst,
  input  spa_pkg::cmd_t  cmd,
  output spa_pkg::sts_t  sts,
  input  spa_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output spa_pkg::out_t  out_data
);

  // Memories.
  logic [spa_pkg::MAP_W-1:0]    id_map     [spa_pkg::MAX_RES];
  logic [spa_pkg::PLACE_W-1:0]  rec_place  [spa_pkg::MAX_SPRITES];
  logic [spa_pkg::BOUNDS_W-1:0] rec_bounds [spa_pkg::MAX_SPRITES];
  logic [spa_pkg::SLOT_W-1:0]   stack      [spa_pkg::MAX_PAGES * spa_pkg::SLOTS_MAX];

  // Per-page registers.
  logic [spa_pkg::CLS_W-1:0]    page_class [spa_pkg::MAX_PAGES];
  logic [spa_pkg::TOP_W-1:0]    free_top   [spa_pkg::MAX_PAGES];

  spa_pkg::in_t                 req;
  spa_pkg::out_t                res;
  spa_pkg::out_t                err_res;
  logic [spa_pkg::CLS_W-1:0]    cls;
  logic [spa_pkg::MAP_W-1:0]    map_q;
  logic [spa_pkg::PLACE_W-1:0]  place_q;
  logic [spa_pkg::BOUNDS_W-1:0] bounds_q;
  logic [spa_pkg::SLOT_W-1:0]   stack_q;
  logic [spa_pkg::PAGE_W-1:0]   cur_pg;
  logic [spa_pkg::PCNT_W-1:0]   page_count;
  logic [spa_pkg::CNT_W-1:0]    record_count;
  logic [spa_pkg::TOP_W-1:0]    fill_k;
  logic [spa_pkg::ID_W-1:0]     clr_addr;

  logic [spa_pkg::CLS_W-1:0]    cur_cls;
  logic [spa_pkg::TOP_W-1:0]    cur_top;
  logic [spa_pkg::TOP_W-1:0]    top_m1;
  logic [spa_pkg::REC_W-1:0]    map_idx;
  logic [spa_pkg::CNT_W-1:0]    cnt_m1;
  logic [spa_pkg::CLS_W-1:0]    cbits;
  logic [spa_pkg::TOP_W-1:0]    n_slots;
  logic                         scan_live;
  logic                         push_ok;

  logic [spa_pkg::SLOT_W-1:0]   col;
  logic [spa_pkg::SLOT_W-1:0]   row;
  logic [21:0]                  left_w;
  logic [21:0]                  top_w;
  logic [spa_pkg::POS_W-1:0]    new_left;
  logic [spa_pkg::POS_W-1:0]    new_top;
  logic [spa_pkg::EDGE_W-1:0]   new_right;
  logic [spa_pkg::EDGE_W-1:0]   new_bottom;

  logic                         map_we;
  logic [spa_pkg::ID_W-1:0]     map_wa;
  logic [spa_pkg::MAP_W-1:0]    map_wd;
  logic                         rec_we;
  logic [spa_pkg::REC_W-1:0]    rec_wa;
  logic [spa_pkg::PLACE_W-1:0]  place_wd;
  logic [spa_pkg::BOUNDS_W-1:0] bounds_wd;
  logic [spa_pkg::REC_W-1:0]    rec_ra;
  logic                         stk_we;
  logic [spa_pkg::STACK_AW-1:0] stk_wa;
  logic [spa_pkg::SLOT_W-1:0]   stk_wd;

  // Lookups at the current page and record.
  assign cur_cls   = page_class[cur_pg];
  assign cur_top   = free_top[cur_pg];
  assign top_m1    = cur_top - spa_pkg::TOP_W'(1);
  assign map_idx   = map_q[spa_pkg::REC_W-1:0];
  assign cnt_m1    = record_count - spa_pkg::CNT_W'(1);
  assign cbits     = spa_pkg::col_bits(cls);
  assign n_slots   = spa_pkg::TOP_W'(1) << {cbits, 1'b0};
  assign scan_live = {1'b0, cur_pg} < page_count;
  assign push_ok   = cur_top < spa_pkg::TOP_W'(spa_pkg::SLOTS_MAX);

  // Placement of the popped slot: column and row of a row-major grid.
  assign col        = stack_q & ((spa_pkg::SLOT_W'(1) << cbits) - spa_pkg::SLOT_W'(1));
  assign row        = stack_q >> cbits;
  assign left_w     = 22'(col) << cls;
  assign top_w      = 22'(row) << cls;
  assign new_left   = left_w[spa_pkg::POS_W-1:0];
  assign new_top    = top_w[spa_pkg::POS_W-1:0];
  assign new_right  = spa_pkg::EDGE_W'(new_left) + spa_pkg::EDGE_W'(req.width);
  assign new_bottom = spa_pkg::EDGE_W'(new_top) + spa_pkg::EDGE_W'(req.height);

  // Status towards the controller.
  always_comb begin
    sts.mode       = req.mode;
    sts.cached     = map_q[spa_pkg::REC_W] && ({1'b0, map_idx} < record_count);
    sts.table_full = record_count == spa_pkg::CNT_W'(spa_pkg::MAX_SPRITES);
    sts.is_last    = map_idx == cnt_m1[spa_pkg::REC_W-1:0];
    sts.scan_match = scan_live && (cur_cls == cls) && (cur_top != '0);
    sts.scan_more  = scan_live && (cur_pg != spa_pkg::PAGE_W'(spa_pkg::MAX_PAGES - 1));
    sts.pages_full = page_count == spa_pkg::PCNT_W'(spa_pkg::MAX_PAGES);
    sts.fill_last  = fill_k == (n_slots - spa_pkg::TOP_W'(1));
    sts.clr_last   = clr_addr == spa_pkg::ID_W'(spa_pkg::MAX_RES - 1);
    sts.out_free   = !out_valid || out_ready;
  end

  // Id map write port.
  always_comb begin
    map_we = 1'b1;
    map_wa = req.resource_id;
    map_wd = '0;
    if (cmd.clear_sweep) begin
      map_wa = clr_addr;
    end else if (cmd.unmap) begin
      map_wa = req.resource_id;
    end else if (cmd.swap_wr) begin
      map_wa = place_q[spa_pkg::ID_W-1:0];
      map_wd = {1'b1, map_idx};
    end else if (cmd.place) begin
      map_wd = {1'b1, record_count[spa_pkg::REC_W-1:0]};
    end else begin
      map_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      id_map[map_wa] <= map_wd;
    end
    if (cmd.take_in) begin
      map_q <= id_map[in_data.resource_id];
    end
  end

  // Record memory ports.
  always_comb begin
    rec_we    = cmd.swap_wr || cmd.place;
    rec_wa    = map_idx;
    place_wd  = place_q;
    bounds_wd = bounds_q;
    if (cmd.place) begin
      rec_wa    = record_count[spa_pkg::REC_W-1:0];
      place_wd  = {cur_pg, stack_q, req.resource_id};
      bounds_wd = {new_left, new_top, new_right, new_bottom};
    end
    rec_ra = cmd.rec_last ? cnt_m1[spa_pkg::REC_W-1:0] : map_idx;
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_place[rec_wa]  <= place_wd;
      rec_bounds[rec_wa] <= bounds_wd;
    end
    if (cmd.rec_rd) begin
      place_q  <= rec_place[rec_ra];
      bounds_q <= rec_bounds[rec_ra];
    end
  end

  // Free slot stacks: fill of a new page, push on invalidate, pop on load.
  always_comb begin
    stk_we = 1'b0;
    stk_wa = {cur_pg, fill_k[spa_pkg::SLOT_W-1:0]};
    stk_wd = fill_k[spa_pkg::SLOT_W-1:0];
    if (cmd.fill) begin
      stk_we = 1'b1;
    end else if (cmd.unmap && push_ok) begin
      stk_we = 1'b1;
      stk_wa = {cur_pg, cur_top[spa_pkg::SLOT_W-1:0]};
      stk_wd = place_q[spa_pkg::ID_W +: spa_pkg::SLOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack[stk_wa] <= stk_wd;
    end
    if (cmd.pop) begin
      stack_q <= stack[{cur_pg, top_m1[spa_pkg::SLOT_W-1:0]}];
    end
  end

  // Per-page class and stack depth.
  always_ff @(posedge clk) begin
    if (cmd.open_page) begin
      page_class[page_count[spa_pkg::PAGE_W-1:0]] <= cls;
    end
    if (cmd.fill && sts.fill_last) begin
      free_top[cur_pg] <= n_slots;
    end else if (cmd.unmap && push_ok) begin
      free_top[cur_pg] <= cur_top + spa_pkg::TOP_W'(1);
    end else if (cmd.pop) begin
      free_top[cur_pg] <= top_m1;
    end
  end

  // Request, page cursor and fill counter.
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      req <= in_data;
      cls <= spa_pkg::size_class(in_data.width, in_data.height);
    end
    if (cmd.scan_start) begin
      cur_pg <= '0;
    end else if (cmd.scan_next) begin
      cur_pg <= cur_pg + spa_pkg::PAGE_W'(1);
    end else if (cmd.open_page) begin
      cur_pg <= page_count[spa_pkg::PAGE_W-1:0];
    end else if (cmd.pg_from_rec) begin
      cur_pg <= place_q[spa_pkg::PLACE_W-1 -: spa_pkg::PAGE_W];
    end
    if (cmd.open_page) begin
      fill_k <= '0;
    end else if (cmd.fill) begin
      fill_k <= fill_k + spa_pkg::TOP_W'(1);
    end
  end

  // Counters and clearing address.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_count   <= '0;
      record_count <= '0;
      clr_addr     <= '0;
    end else begin
      if (cmd.open_page) begin
        page_count <= page_count + spa_pkg::PCNT_W'(1);
      end
      if (cmd.place) begin
        record_count <= record_count + spa_pkg::CNT_W'(1);
      end else if (cmd.dec) begin
        record_count <= cnt_m1;
      end
      if (cmd.clear_sweep) begin
        clr_addr <= clr_addr + spa_pkg::ID_W'(1);
      end
    end
  end

  // Error result: only the status is set.
  always_comb begin
    err_res        = '0;
    err_res.status = cmd.err_code;
  end

  // Result staging.
  always_ff @(posedge clk) begin
    if (cmd.res_err) begin
      res <= err_res;
    end else if (cmd.res_rec) begin
      res.hit        <= !req.mode;
      res.status     <= spa_pkg::ST_OK;
      res.page_index <= place_q[spa_pkg::PLACE_W-1 -: spa_pkg::PAGE_W];
      res.slot       <= place_q[spa_pkg::ID_W +: spa_pkg::SLOT_W];
      res.left       <= bounds_q[spa_pkg::BOUNDS_W-1 -: spa_pkg::POS_W];
      res.top        <= bounds_q[2*spa_pkg::EDGE_W +: spa_pkg::POS_W];
      res.right      <= bounds_q[spa_pkg::EDGE_W +: spa_pkg::EDGE_W];
      res.bottom     <= bounds_q[spa_pkg::EDGE_W-1:0];
      res.cell_size  <= spa_pkg::CELL_W'(1) << cur_cls;
    end else if (cmd.place) begin
      res.hit        <= 1'b0;
      res.status     <= spa_pkg::ST_OK;
      res.page_index <= cur_pg;
      res.slot       <= stack_q;
      res.left       <= new_left;
      res.top        <= new_top;
      res.right      <= new_right;
      res.bottom     <= new_bottom;
      res.cell_size  <= spa_pkg::CELL_W'(1) << cls;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= res;
    end
  end

  a_rec_bound: assert property (@(posedge clk) disable iff (rst)
    record_count <= spa_pkg::CNT_W'(spa_pkg::MAX_SPRITES))
    else $error("record count beyond table size");

  a_page_bound: assert property (@(posedge clk) disable iff (rst)
    page_count <= spa_pkg::PCNT_W'(spa_pkg::MAX_PAGES))
    else $error("page count beyond atlas size");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (cur_top != '0))
    else $error("pop from an empty slot stack");

  a_place_room: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> (record_count < spa_pkg::CNT_W'(spa_pkg::MAX_SPRITES)))
    else $error("record placed into a full table");

endmodule
